// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)

`define ASSERT_NORST(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/bpfa_pkg.sv -----
package bpfa_pkg;

  localparam int BITMAP_WORDS_DEF = 1024;
  localparam int FRAME_BYTES_DEF  = 4096;
  localparam int LARGE_BYTES_DEF  = 2097152;

  localparam int OP_W     = 3;
  localparam int ADDR_W   = 27;
  localparam int SIZE_W   = 28;
  localparam int USED_W   = 16;
  localparam int MAXB_W   = 16;
  localparam int WORD_W   = 32;
  localparam int LIM_W    = 17;

  localparam logic [USED_W-1:0] USED_RESET = 16'h8000;
  localparam logic [WORD_W-1:0] WORD_FULL  = 32'hffff_ffff;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC      = 3'd0,
    OP_FREE       = 3'd1,
    OP_FREE_LARGE = 3'd2,
    OP_MARK_USED  = 3'd3,
    OP_MARK_FREE  = 3'd4
  } op_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic run;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_hit;
    logic scan_empty;
    logic run_idle;
  } stat_t;

endpackage

// ----- rtl/bpfa_ctrl.sv -----
`include "assert_macros.svh"

module bpfa_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [bpfa_pkg::OP_W-1:0] opcode,
  input  bpfa_pkg::stat_t         stat,
  output bpfa_pkg::cmd_t          cmd,
  output logic                    busy,
  output logic                    done
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RUN
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          if (stat.clr_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            case (bpfa_pkg::op_t'(opcode))
              bpfa_pkg::OP_ALLOC: begin
                state <= ST_SCAN;
              end
              bpfa_pkg::OP_FREE,
              bpfa_pkg::OP_FREE_LARGE,
              bpfa_pkg::OP_MARK_USED,
              bpfa_pkg::OP_MARK_FREE: begin
                state <= ST_RUN;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (stat.scan_hit || stat.scan_empty) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        ST_RUN: begin
          if (stat.run_idle) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd.clear = (state == ST_CLEAR);
    cmd.load  = (state == ST_IDLE) && start;
    cmd.scan  = (state == ST_SCAN);
    cmd.run   = (state == ST_RUN);
    busy      = (state != ST_IDLE);
  end

  `ASSERT_CLK(a_accept_leads_on, clk, rst, (start && !busy) |=> (busy || done), "accepted item neither busy nor done")
  `ASSERT_CLK(a_done_after_work, clk, rst, done |-> $past(state != ST_CLEAR), "result strobe during clearing pass")
  `ASSERT_NORST(a_reset_clears, clk, $past(rst) |-> (state == ST_CLEAR && !done), "reset did not start clearing pass")

endmodule

// ----- rtl/bpfa_dpath.sv -----
`include "assert_macros.svh"

module bpfa_dpath #(
  parameter int BITMAP_WORDS = bpfa_pkg::BITMAP_WORDS_DEF,
  parameter int FRAME_BYTES  = bpfa_pkg::FRAME_BYTES_DEF,
  parameter int LARGE_BYTES  = bpfa_pkg::LARGE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bpfa_pkg::cmd_t                cmd,
  output bpfa_pkg::stat_t               stat,
  input  logic                          max_blocks_we,
  input  logic [bpfa_pkg::MAXB_W-1:0]   max_blocks,
  input  logic [bpfa_pkg::OP_W-1:0]     opcode,
  input  logic [bpfa_pkg::ADDR_W-1:0]   address,
  input  logic [bpfa_pkg::SIZE_W-1:0]   region_size,
  output logic [bpfa_pkg::ADDR_W-1:0]   frame_address,
  output logic                          out_of_memory,
  output logic [bpfa_pkg::USED_W-1:0]   used_count
);

  localparam int FRAME_SHIFT  = $clog2(FRAME_BYTES);
  localparam int LARGE_FRAMES = LARGE_BYTES / FRAME_BYTES;
  localparam int CAP          = BITMAP_WORDS * 32;
  localparam int CAP_W        = $clog2(CAP + 1);
  localparam int CNT_W        = bpfa_pkg::SIZE_W + 1 - FRAME_SHIFT;
  localparam int RUN_W        = ((CAP_W > CNT_W) ? CAP_W : CNT_W) + 1;
  localparam int WA_W         = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int SP_W         = $clog2(BITMAP_WORDS + 1);

  logic [bpfa_pkg::WORD_W-1:0] mem [BITMAP_WORDS];
  logic [bpfa_pkg::WORD_W-1:0] rdata;
  logic                        mem_we;
  logic [WA_W-1:0]             mem_wa;
  logic [bpfa_pkg::WORD_W-1:0] mem_wd;
  logic [WA_W-1:0]             mem_ra;

  logic [bpfa_pkg::MAXB_W-1:0] max_blocks_q;
  logic [WA_W-1:0]             clr_ptr;

  logic [SP_W-1:0]             sp;
  logic [SP_W-1:0]             scan_lim;
  logic [bpfa_pkg::LIM_W-1:0]  lim_full;
  logic                        rd_valid;
  logic [WA_W-1:0]             rd_idx;
  logic [bpfa_pkg::WORD_W-1:0] scan_word;
  logic [4:0]                  free_pos;
  logic                        scan_issue;
  logic                        hit;

  logic [RUN_W-1:0]            cur;
  logic [RUN_W-1:0]            rem;
  logic                        set_used;
  logic                        run_issue;
  logic [5:0]                  room;
  logic [5:0]                  step;
  logic [32:0]                 ones;
  logic [bpfa_pkg::WORD_W-1:0] run_mask;
  logic                        wb_valid;
  logic [WA_W-1:0]             wb_addr;
  logic [bpfa_pkg::WORD_W-1:0] wb_mask;

  logic [RUN_W-1:0]            first;
  logic [RUN_W-1:0]            count;
  logic [RUN_W-1:0]            avail;
  logic [RUN_W-1:0]            eff;
  logic [bpfa_pkg::SIZE_W:0]   size_up;
  logic                        is_run;

  always_comb begin
    lim_full = {{(bpfa_pkg::LIM_W - bpfa_pkg::MAXB_W + 5){1'b0}},
                max_blocks_q[bpfa_pkg::MAXB_W-1:5]};
    if (lim_full > bpfa_pkg::LIM_W'(BITMAP_WORDS)) begin
      lim_full = bpfa_pkg::LIM_W'(BITMAP_WORDS);
    end
    scan_lim   = lim_full[SP_W-1:0];
    scan_issue = cmd.scan && (sp < scan_lim);
    scan_word  = rdata | ((rd_idx == '0) ? 32'd1 : 32'd0);
    hit        = cmd.scan && rd_valid && (scan_word != bpfa_pkg::WORD_FULL);
    free_pos   = 5'd0;
    for (int j = 31; j >= 0; j--) begin
      if (!scan_word[j]) begin
        free_pos = 5'(j);
      end
    end
  end

  always_comb begin
    run_issue = cmd.run && (rem != '0);
    room      = 6'd32 - {1'b0, cur[4:0]};
    step      = (rem < RUN_W'(room)) ? rem[5:0] : room;
    ones      = (33'd1 << step) - 33'd1;
    run_mask  = ones[31:0] << cur[4:0];
  end

  always_comb begin
    first   = RUN_W'(address >> FRAME_SHIFT);
    size_up = {1'b0, region_size} + (bpfa_pkg::SIZE_W + 1)'(FRAME_BYTES - 1);
    is_run  = 1'b1;
    case (bpfa_pkg::op_t'(opcode))
      bpfa_pkg::OP_FREE:       count = RUN_W'(1);
      bpfa_pkg::OP_FREE_LARGE: count = RUN_W'(LARGE_FRAMES);
      bpfa_pkg::OP_MARK_USED:  count = RUN_W'(region_size >> FRAME_SHIFT);
      bpfa_pkg::OP_MARK_FREE:  count = RUN_W'(size_up >> FRAME_SHIFT);
      default: begin
        count  = '0;
        is_run = 1'b0;
      end
    endcase
    avail = RUN_W'(CAP) - first;
    if (first >= RUN_W'(CAP)) begin
      eff = '0;
    end else if (count < avail) begin
      eff = count;
    end else begin
      eff = avail;
    end
  end

  always_comb begin
    mem_ra = cmd.run ? cur[5 +: WA_W] : sp[WA_W-1:0];
    mem_we = 1'b1;
    mem_wa = wb_addr;
    mem_wd = set_used ? (rdata | wb_mask) : (rdata & ~wb_mask);
    if (cmd.clear) begin
      mem_wa = clr_ptr;
      mem_wd = bpfa_pkg::WORD_FULL;
    end else if (hit) begin
      mem_wa = rd_idx;
      mem_wd = scan_word | (32'd1 << free_pos);
    end else if (!wb_valid) begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_blocks_q  <= '0;
      clr_ptr       <= '0;
      used_count    <= bpfa_pkg::USED_RESET;
      rd_valid      <= 1'b0;
      wb_valid      <= 1'b0;
      rem           <= '0;
      sp            <= '0;
      out_of_memory <= 1'b0;
      frame_address <= '0;
    end else begin
      if (max_blocks_we) begin
        max_blocks_q <= max_blocks;
      end
      if (cmd.clear) begin
        clr_ptr <= clr_ptr + WA_W'(1);
      end
      rd_valid <= scan_issue;
      wb_valid <= run_issue;
      if (scan_issue) begin
        rd_idx <= sp[WA_W-1:0];
        sp     <= sp + SP_W'(1);
      end
      if (run_issue) begin
        wb_addr <= cur[5 +: WA_W];
        wb_mask <= run_mask;
        cur     <= cur + RUN_W'(step);
        rem     <= rem - RUN_W'(step);
      end
      if (cmd.load) begin
        frame_address <= '0;
        out_of_memory <= 1'b0;
        sp            <= '0;
        rd_valid      <= 1'b0;
        wb_valid      <= 1'b0;
        cur           <= first;
        rem           <= eff;
        set_used      <= (bpfa_pkg::op_t'(opcode) == bpfa_pkg::OP_MARK_USED);
        if (is_run) begin
          if (bpfa_pkg::op_t'(opcode) == bpfa_pkg::OP_MARK_USED) begin
            used_count <= used_count + eff[bpfa_pkg::USED_W-1:0];
          end else begin
            used_count <= used_count - eff[bpfa_pkg::USED_W-1:0];
          end
        end
      end
      if (hit) begin
        used_count    <= used_count + bpfa_pkg::USED_W'(1);
        frame_address <= bpfa_pkg::ADDR_W'({rd_idx, free_pos, {FRAME_SHIFT{1'b0}}});
      end
      if (stat.scan_empty) begin
        out_of_memory <= 1'b1;
      end
    end
  end

  always_comb begin
    stat.clr_last   = (clr_ptr == WA_W'(BITMAP_WORDS - 1));
    stat.scan_hit   = hit;
    stat.scan_empty = cmd.scan && !rd_valid && !scan_issue;
    stat.run_idle   = cmd.run && (rem == '0) && !wb_valid;
  end

  `ASSERT_CLK(a_one_writer, clk, rst, !(wb_valid && (hit || cmd.clear)), "two writers on the bitmap port")
  `ASSERT_CLK(a_oom_zero_addr, clk, rst, out_of_memory |-> (frame_address == '0), "failed allocate with nonzero address")
  `ASSERT_CLK(a_hit_count, clk, rst, hit |=> (used_count == $past(used_count) + bpfa_pkg::USED_W'(1)), "allocate did not bump the count")

endmodule

// ----- rtl/bitmap_page_frame_allocator.sv -----
// Channel   Handshake               Payload
// command   start, busy             opcode, address, region_size
// result    done (one-cycle strobe) frame_address, out_of_memory, used_count
// config    max_blocks_we           max_blocks
//
// After reset a clearing pass fills all BITMAP_WORDS bitmap words with ones, one a cycle,
// with busy high; configuration writes are taken meanwhile.
// A failing allocate scans min(floor(max_blocks/32), BITMAP_WORDS) bitmap words before done;
// a free frame found early ends the scan sooner.
// Free and mark commands update each bitmap word of the run by reading it and writing it back.
// An unknown opcode strobes done in the cycle after its accept; the receiver cannot stall.
module bitmap_page_frame_allocator #(
  parameter int BITMAP_WORDS = bpfa_pkg::BITMAP_WORDS_DEF,
  parameter int FRAME_BYTES  = bpfa_pkg::FRAME_BYTES_DEF,
  parameter int LARGE_BYTES  = bpfa_pkg::LARGE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bpfa_pkg::OP_W-1:0]     opcode,
  input  logic [bpfa_pkg::ADDR_W-1:0]   address,
  input  logic [bpfa_pkg::SIZE_W-1:0]   region_size,
  output logic                          done,
  output logic [bpfa_pkg::ADDR_W-1:0]   frame_address,
  output logic                          out_of_memory,
  output logic [bpfa_pkg::USED_W-1:0]   used_count,
  input  logic                          max_blocks_we,
  input  logic [bpfa_pkg::MAXB_W-1:0]   max_blocks
);

  bpfa_pkg::cmd_t  cmd;
  bpfa_pkg::stat_t stat;

  bpfa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bpfa_dpath #(
    .BITMAP_WORDS (BITMAP_WORDS),
    .FRAME_BYTES  (FRAME_BYTES),
    .LARGE_BYTES  (LARGE_BYTES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .max_blocks_we (max_blocks_we),
    .max_blocks    (max_blocks),
    .opcode        (opcode),
    .address       (address),
    .region_size   (region_size),
    .frame_address (frame_address),
    .out_of_memory (out_of_memory),
    .used_count    (used_count)
  );

endmodule

// ----- tb/tb_bitmap_page_frame_allocator.sv -----
module tb_bitmap_page_frame_allocator;
  import bpfa_pkg::*;

  localparam int CAP_FRAMES = BITMAP_WORDS_DEF * WORD_W;
  localparam int LARGE_FRAMES = LARGE_BYTES_DEF / FRAME_BYTES_DEF;
  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_LAST = 3'd7;
  localparam logic [ADDR_W-1:0] ADDR_MAX = 27'h7ff_ffff;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 28'h800_0000;
  localparam logic [MAXB_W-1:0] PRESENT_MAX = 16'h8000;
  localparam int PHASE_ITEMS = 380;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_addr;
    logic              oom;
    logic [USED_W-1:0] used;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] opcode = '0;
  logic [ADDR_W-1:0] address = '0;
  logic [SIZE_W-1:0] region_size = '0;
  logic done;
  logic [ADDR_W-1:0] frame_address;
  logic out_of_memory;
  logic [USED_W-1:0] used_count;
  logic max_blocks_we = 1'b0;
  logic [MAXB_W-1:0] max_blocks = '0;

  alloc_result_t pending_results[$];
  logic [WORD_W-1:0] frame_bits [BITMAP_WORDS_DEF];
  logic [USED_W-1:0] used_total;
  logic [MAXB_W-1:0] frames_present;
  int mismatches = 0;
  int idle_burst = 0;

  bitmap_page_frame_allocator uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .address(address),
    .region_size(region_size),
    .done(done),
    .frame_address(frame_address),
    .out_of_memory(out_of_memory),
    .used_count(used_count),
    .max_blocks_we(max_blocks_we),
    .max_blocks(max_blocks)
  );

  always #5 clk = ~clk;

  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic reset_allocator_model();
    for (int i = 0; i < BITMAP_WORDS_DEF; i++) frame_bits[i] = WORD_FULL;
    used_total = USED_RESET;
    frames_present = '0;
  endtask

  // Frames past the end of the bitmap are skipped and leave the count alone.
  function automatic void touch_frames(int first, int count, bit set_used);
    int n;
    for (int k = 0; k < count; k++) begin
      n = first + k;
      if (n >= CAP_FRAMES) break;
      frame_bits[n / WORD_W][n % WORD_W] = set_used;
      if (set_used) used_total = used_total + 1'b1;
      else used_total = used_total - 1'b1;
    end
  endfunction

  function automatic int lowest_free_frame();
    int words;
    words = frames_present / WORD_W;
    if (words > BITMAP_WORDS_DEF) words = BITMAP_WORDS_DEF;
    for (int i = 0; i < words; i++) begin
      if (frame_bits[i] != WORD_FULL) begin
        for (int j = 0; j < WORD_W; j++) begin
          if (!frame_bits[i][j] && (i != 0 || j != 0)) return i * WORD_W + j;
        end
      end
    end
    return 0;
  endfunction

  function automatic alloc_result_t predict_command(logic [OP_W-1:0] op,
                                                    logic [ADDR_W-1:0] addr,
                                                    logic [SIZE_W-1:0] size);
    alloc_result_t r;
    int first;
    int n;
    r = '0;
    first = addr / FRAME_BYTES_DEF;
    case (op)
      OP_ALLOC: begin
        n = lowest_free_frame();
        if (n == 0) begin
          r.oom = 1'b1;
        end else begin
          frame_bits[n / WORD_W][n % WORD_W] = 1'b1;
          used_total = used_total + 1'b1;
          r.frame_addr = ADDR_W'(longint'(n) * FRAME_BYTES_DEF);
        end
      end
      OP_FREE: touch_frames(first, 1, 1'b0);
      OP_FREE_LARGE: touch_frames(first, LARGE_FRAMES, 1'b0);
      OP_MARK_USED: touch_frames(first, int'(size) / FRAME_BYTES_DEF, 1'b1);
      OP_MARK_FREE: touch_frames(first, (int'(size) + FRAME_BYTES_DEF - 1) / FRAME_BYTES_DEF,
                                 1'b0);
      default: ;
    endcase
    r.used = used_total;
    return r;
  endfunction

  function automatic void note_mismatch(string what, alloc_result_t want, alloc_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s: expected addr %h oom %b used %h, got addr %h oom %b used %h",
               $realtime, what, want.frame_addr, want.oom, want.used,
               got.frame_addr, got.oom, got.used);
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    if (!rst && done) begin
      got = {frame_address, out_of_memory, used_count};
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.frame_addr !== want.frame_addr || got.oom !== want.oom ||
            got.used !== want.used)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                          input logic [SIZE_W-1:0] size);
    int gap;
    if (idle_burst > 0) begin
      gap = 0;
      idle_burst--;
    end else if ($urandom_range(0, 19) == 0) begin
      gap = 0;
      idle_burst = $urandom_range(10, 40);
    end else begin
      gap = $urandom_range(0, 11);
    end
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    opcode = op;
    address = addr;
    region_size = size;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_command(op, addr, size));
  endtask

  task automatic set_max_blocks(input logic [MAXB_W-1:0] value);
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
    max_blocks_we = 1'b1;
    max_blocks = value;
    @(negedge clk);
    max_blocks_we = 1'b0;
    frames_present = value;
  endtask

  function automatic logic [ADDR_W-1:0] pick_address(int span);
    return ADDR_W'(longint'($urandom_range(0, span - 1)) * FRAME_BYTES_DEF +
                   $urandom_range(0, FRAME_BYTES_DEF - 1));
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 2) return SIZE_W'($urandom_range(0, SIZE_MAX));
    if (sel < 40) return SIZE_W'($urandom_range(0, 16) * FRAME_BYTES_DEF);
    return SIZE_W'($urandom_range(0, 16 * FRAME_BYTES_DEF));
  endfunction

  // With the bitmap still fully used, every scan must come up empty.
  task automatic test_empty_scan();
    set_max_blocks('0);
    send_cmd(OP_ALLOC, '0, '0);
    for (int op = OP_RSVD_FIRST; op <= OP_RSVD_LAST; op++)
      send_cmd(OP_W'(op), ADDR_MAX, SIZE_MAX);
    set_max_blocks(PRESENT_MAX);
    send_cmd(OP_ALLOC, '0, '0);
  endtask

  task automatic test_run_edges();
    set_max_blocks(16'd63);
    send_cmd(OP_MARK_FREE, '0, SIZE_W'(1));
    send_cmd(OP_ALLOC, ADDR_MAX, SIZE_MAX);
    send_cmd(OP_FREE, ADDR_W'(40 * FRAME_BYTES_DEF + 123), '0);
    send_cmd(OP_ALLOC, '0, '0);
    set_max_blocks(16'd64);
    send_cmd(OP_ALLOC, '0, '0);
    send_cmd(OP_MARK_USED, ADDR_W'(7 * FRAME_BYTES_DEF), SIZE_W'(FRAME_BYTES_DEF - 1));
    send_cmd(OP_MARK_FREE, ADDR_W'(7 * FRAME_BYTES_DEF), '0);
    send_cmd(OP_MARK_USED, ADDR_W'(7 * FRAME_BYTES_DEF), SIZE_W'(FRAME_BYTES_DEF));
    send_cmd(OP_MARK_FREE, ADDR_W'(7 * FRAME_BYTES_DEF), SIZE_W'(FRAME_BYTES_DEF + 1));
    send_cmd(OP_ALLOC, '0, '0);
    send_cmd(OP_FREE_LARGE, '0, '0);
    send_cmd(OP_ALLOC, '0, '0);
    send_cmd(OP_FREE_LARGE, ADDR_MAX, '0);
    send_cmd(OP_MARK_FREE, '0, SIZE_MAX);
    send_cmd(OP_MARK_USED, ADDR_MAX, SIZE_MAX);
    send_cmd(OP_MARK_USED, '0, SIZE_MAX);
    send_cmd(OP_FREE, ADDR_MAX, '0);
  endtask

  // Addresses mostly fall in a window near the scanned range so that frees
  // keep feeding the allocator.
  task automatic test_random_phase(input logic [MAXB_W-1:0] present, input int items);
    int span;
    int sel;
    logic [OP_W-1:0] op;
    logic [ADDR_W-1:0] addr;
    set_max_blocks(present);
    span = (present < 64) ? 64 : ((present > 4096) ? 4096 : int'(present));
    for (int i = 0; i < items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) op = OP_ALLOC;
      else if (sel < 55) op = OP_FREE;
      else if (sel < 59) op = OP_FREE_LARGE;
      else if (sel < 76) op = OP_MARK_USED;
      else if (sel < 96) op = OP_MARK_FREE;
      else op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
      addr = ($urandom_range(0, 4) == 0) ? pick_address(CAP_FRAMES) : pick_address(span);
      send_cmd(op, addr, pick_size());
    end
  endtask

  initial begin
    reset_allocator_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_scan();
    test_run_edges();
    test_random_phase(PRESENT_MAX, PHASE_ITEMS);
    test_random_phase(16'd17, PHASE_ITEMS);
    test_random_phase(16'd65, PHASE_ITEMS);
    test_random_phase(MAXB_W'($urandom_range(0, PRESENT_MAX)), PHASE_ITEMS);
    test_random_phase(16'd1000, PHASE_ITEMS);
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bpfa_pkg.sv
rtl/bpfa_ctrl.sv
rtl/bpfa_dpath.sv
rtl/bitmap_page_frame_allocator.sv
tb/tb_bitmap_page_frame_allocator.sv
